[sv/stalt_pkg.sv]
// Shared widths, register map and result flag type for the STA/LTA trigger.
package stalt_pkg;

	localparam int SAMPLE_W = 16;
	localparam int RATIO_W  = 16;
	localparam int APB_DW   = 32;
	localparam int APB_AW   = 3;

	// Register index, taken from paddr[2]
	typedef enum logic {
		REG_TRIGGER_RATIO = 1'b0,
		REG_RELEASE_RATIO = 1'b1
	} stalt_reg_t;

	localparam logic [RATIO_W-1:0] TRIGGER_RESET = 16'd205;
	localparam logic [RATIO_W-1:0] RELEASE_RESET = 16'd154;

	typedef struct packed {
		logic zero_long_average;
		logic event_end;
		logic event_start;
		logic event_active;
	} stalt_flags_t;

endpackage

[sv/sta_lta_event_trigger.sv]
// Top level of the STA/LTA event trigger: sample shift line, running sums, APB registers.
//
// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  s_tdata[15:0] = sample
// m_        out        m_tvalid/m_tready  m_tdata[7:0]: active, start, end, zero_long_average
// APB       in         psel/penable       trigger_ratio at 0x0, release_ratio at 0x4
//
// One sample is accepted per cycle while m_tready keeps the output moving; each result
// passes the sum stage and then the four stages of the multiply/compare pipeline.
// Reset clears the whole history line, the sums and the event state and loads the
// threshold reset values at once, so samples are taken from the first cycle after reset.
// Stalls on m_tready back up stage by stage; s_tready drops only when all stages are full.
module sta_lta_event_trigger import stalt_pkg::*; #(
	parameter int STA_LEN = 32,
	parameter int LTA_LEN = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,   // [15:0] sample
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,   // [0] event_active, [1] event_start,
	                                     // [2] event_end, [3] zero_long_average
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int SW       = SAMPLE_W + $clog2(STA_LEN);
	localparam int LW       = SAMPLE_W + $clog2(LTA_LEN);
	localparam int RING_LEN = (STA_LEN > LTA_LEN) ? STA_LEN : LTA_LEN;

	logic [RATIO_W-1:0]  trigger_ratio_q, release_ratio_q;
	stalt_reg_t          reg_sel;
	logic                cfg_wr;

	logic [SAMPLE_W-1:0] ring [RING_LEN];
	logic                accept;
	logic [SW-1:0]       short_sum_q, short_next;
	logic [LW-1:0]       long_sum_q, long_next;
	logic                v_s1;
	logic [SW-1:0]       short_s1;
	logic [LW-1:0]       long_s1;
	logic                rdy1, ratio_ready;
	stalt_flags_t        flags;

	// Configuration registers
	assign pready  = 1'b1;
	assign reg_sel = stalt_reg_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trigger_ratio_q <= TRIGGER_RESET;
			release_ratio_q <= RELEASE_RESET;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_TRIGGER_RATIO: trigger_ratio_q <= pwdata[RATIO_W-1:0];
				REG_RELEASE_RATIO: release_ratio_q <= pwdata[RATIO_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_TRIGGER_RATIO: prdata = APB_DW'(trigger_ratio_q);
			REG_RELEASE_RATIO: prdata = APB_DW'(release_ratio_q);
			default:           prdata = '0;
		endcase
	end

	// History line: newest sample in cell 0, shift on every accepted transaction
	assign rdy1     = !v_s1 || ratio_ready;
	assign s_tready = rdy1;
	assign accept   = s_tvalid && s_tready;

	for (genvar k = 0; k < RING_LEN; k++) begin : g_cell
		if (k == 0) begin : g_head
			stalt_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (accept),
				.d        (s_tdata),
				.q        (ring[k])
			);
		end else begin : g_body
			stalt_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (accept),
				.d        (ring[k-1]),
				.q        (ring[k])
			);
		end
	end

	// Drop the sample leaving each window, add the new one
	assign short_next = short_sum_q + SW'(s_tdata) - SW'(ring[STA_LEN-1]);
	assign long_next  = long_sum_q + LW'(s_tdata) - LW'(ring[LTA_LEN-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_sum_q <= '0;
			long_sum_q  <= '0;
			v_s1        <= 1'b0;
		end else begin
			if (accept) begin
				short_sum_q <= short_next;
				long_sum_q  <= long_next;
			end
			if (rdy1) v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			short_s1 <= short_next;
			long_s1  <= long_next;
		end
	end

	stalt_ratio #(
		.STA_LEN (STA_LEN),
		.LTA_LEN (LTA_LEN)
	) u_ratio (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (v_s1),
		.in_ready      (ratio_ready),
		.short_sum     (short_s1),
		.long_sum      (long_s1),
		.trigger_ratio (trigger_ratio_q),
		.release_ratio (release_ratio_q),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_flags     (flags)
	);

	assign m_tdata = {4'b0000, flags.zero_long_average, flags.event_end,
	                  flags.event_start, flags.event_active};

endmodule

[sv/stalt_cell.sv]
// One sample cell of the history shift line.
module stalt_cell import stalt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                shift_en,
	input  logic [SAMPLE_W-1:0] d,
	output logic [SAMPLE_W-1:0] q
);

	logic [SAMPLE_W-1:0] sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (shift_en) begin
			sample_q <= d;
		end
	end

	assign q = sample_q;

endmodule

[sv/stalt_ratio.sv]
// Cross-multiplied ratio compare and hysteresis, with output register.
module stalt_ratio import stalt_pkg::*; #(
	parameter int STA_LEN = 32,
	parameter int LTA_LEN = 256
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [SAMPLE_W+$clog2(STA_LEN)-1:0]     short_sum,
	input  logic [SAMPLE_W+$clog2(LTA_LEN)-1:0]     long_sum,
	input  logic [RATIO_W-1:0]                      trigger_ratio,
	input  logic [RATIO_W-1:0]                      release_ratio,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output stalt_flags_t                            out_flags
);

	localparam int SW = SAMPLE_W + $clog2(STA_LEN);
	localparam int LW = SAMPLE_W + $clog2(LTA_LEN);
	localparam int MW = RATIO_W + LW;
	localparam int PW = SW + LW;

	logic          v_s2, v_s3, v_s4, v_out_q;
	logic          rdy2, rdy3, rdy4, rdy_out;
	logic [PW-1:0] lhs_s2, lhs_s3;
	logic [MW-1:0] mt_s2, mr_s2;
	logic [PW-1:0] rt_s3, rr_s3;
	logic          zero_s2, zero_s3, zero_s4;
	logic          gt_s4, lt_s4;
	logic          in_event_q;
	stalt_flags_t  flags_q;
	logic          start_c, end_c, in_event_c;

	assign rdy_out  = !v_out_q || out_ready;
	assign rdy4     = !v_s4 || rdy_out;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign in_ready = rdy2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (rdy2)    v_s2    <= in_valid;
			if (rdy3)    v_s3    <= v_s2;
			if (rdy4)    v_s4    <= v_s3;
			if (rdy_out) v_out_q <= v_s4;
		end
	end

	// Stage 2: scale the short sum, multiply long sum by each threshold
	always_ff @(posedge clk) begin
		if (rdy2) begin
			lhs_s2  <= (PW'(short_sum) * PW'(LTA_LEN)) << 8;
			mt_s2   <= MW'(trigger_ratio) * MW'(long_sum);
			mr_s2   <= MW'(release_ratio) * MW'(long_sum);
			zero_s2 <= (long_sum == '0);
		end
	end

	// Stage 3: scale by the short window length
	always_ff @(posedge clk) begin
		if (rdy3) begin
			lhs_s3  <= lhs_s2;
			rt_s3   <= PW'(mt_s2) * PW'(STA_LEN);
			rr_s3   <= PW'(mr_s2) * PW'(STA_LEN);
			zero_s3 <= zero_s2;
		end
	end

	// Stage 4: compare
	always_ff @(posedge clk) begin
		if (rdy4) begin
			gt_s4   <= lhs_s3 > rt_s3;
			lt_s4   <= lhs_s3 < rr_s3;
			zero_s4 <= zero_s3;
		end
	end

	always_comb begin
		start_c    = 1'b0;
		end_c      = 1'b0;
		in_event_c = in_event_q;
		if (!zero_s4) begin
			if (!in_event_q && gt_s4) begin
				start_c    = 1'b1;
				in_event_c = 1'b1;
			end else if (in_event_q && lt_s4) begin
				end_c      = 1'b1;
				in_event_c = 1'b0;
			end
		end
	end

	// Event state advances only when an item moves into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_event_q <= 1'b0;
		end else if (rdy_out && v_s4) begin
			in_event_q <= in_event_c;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && v_s4) begin
			flags_q.event_active      <= in_event_c;
			flags_q.event_start       <= start_c;
			flags_q.event_end         <= end_c;
			flags_q.zero_long_average <= zero_s4;
		end
	end

	assign out_valid = v_out_q;
	assign out_flags = flags_q;

endmodule
